### rtl/core/fcl_pkg.sv
// fcl_pkg: sizes, codes and shared types of the dense layer forward block
// depends on nothing; every other file of the block but fcl_ram imports it
package fcl_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_NEURONS = 64;
    localparam int W_DEPTH     = MAX_INPUTS * MAX_NEURONS;

    localparam int IN_AW  = $clog2(MAX_INPUTS);
    localparam int NEU_AW = $clog2(MAX_NEURONS);
    localparam int W_AW   = $clog2(W_DEPTH);

    // fixed field widths of the channels
    localparam int FUNC_W     = 2;
    localparam int PIDX_W     = 12;
    localparam int VAL_W      = 16;
    localparam int NEURON_W   = 6;
    localparam int RES_W      = 32;
    localparam int DIM_W      = 7;
    localparam int FRAC_W     = 12;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    // products are 2*VAL_W wide, one guard bit per doubling of terms plus the bias
    localparam int ACC_W = 2 * VAL_W + IN_AW + 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD_W = 2'd0,
        FN_LOAD_B = 2'd1,
        FN_ELEM   = 2'd2
    } t_func;

    typedef enum logic {
        REG_INPUTS  = 1'b0,
        REG_NEURONS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] kdim;
        logic [DIM_W-1:0] ndim;
        logic             clr;
    } t_cfg;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] result;
    } t_mac_sts;

endpackage

### rtl/core/fcl_ifs.sv
// fcl_in_if / fcl_out_if: valid-ready channels for input words and result words
// depends on fcl_pkg for the field widths
interface fcl_in_if import fcl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [PIDX_W-1:0]       param_index;
    logic signed [VAL_W-1:0] value;

    modport source(output valid, output func, output param_index, output value, input ready);
    modport sink(input valid, input func, input param_index, input value, output ready);
endinterface

interface fcl_out_if import fcl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [NEURON_W-1:0]     neuron;
    logic signed [RES_W-1:0] result_value;
    logic                    last;

    modport source(output valid, output neuron, output result_value, output last, input ready);
    modport sink(input valid, input neuron, input result_value, input last, output ready);
endinterface

### rtl/core/fully_connected_layer_forward.sv
// fully_connected_layer_forward: dense layer forward pass, top level and sequencer
// depends on fcl_pkg, fcl_ifs, fcl_ram, fcl_cfg and fcl_mac
//
// usage
// - i_in carries words of three kinds: a weight load (param_index is
//   neuron*inputs_per_pattern+element), a bias load (param_index is the neuron)
//   and a pattern element, each taken only while the block is idle.
// - when the last element of a pattern arrives, i_in.ready drops and the block
//   runs one multiply-accumulate per cycle of each element sweep through a single
//   shared mac unit, neuron by neuron, element by element.
// - each neuron passes through the element sweep, two memory/product stages,
//   the accumulate and the hand-off to the output register.
// - o_res gives neuron_count result words in ascending neuron order, last set
//   on the final one. a stalled receiver holds the sequencer in its hand-off
//   step; the output register lets the next input word in while the final
//   result still waits.
// - the apb port sets inputs_per_pattern (0x0) and neuron_count (0x4); a write
//   drops a partly received pattern. write it only while the block is idle.
// - reset restores both dimensions to 64 and clears the element count; the
//   weight, bias and pattern memories are not cleared and must be loaded.
module fully_connected_layer_forward import fcl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    fcl_in_if.sink                i_in,
    fcl_out_if.source             o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_PUSH
    } t_state;

    t_state                  r_state;
    logic [DIM_W-1:0]        r_elem_cnt;
    logic [IN_AW-1:0]        r_elem;
    logic [NEU_AW-1:0]       r_neuron;
    logic [W_AW-1:0]         r_base;
    t_mac_ctl                r_s1_ctl;
    logic                    r_out_vld;
    logic [NEU_AW-1:0]       r_out_neuron;
    logic signed [RES_W-1:0] r_out_val;
    logic                    r_out_last;

    t_cfg              w_cfg;
    t_mac_sts          w_mac_sts;
    t_func             func;
    logic              in_acc;
    logic              we_w;
    logic              we_b;
    logic              we_x;
    logic              start;
    logic [DIM_W-1:0]  n_elem_cnt;
    logic [IN_AW-1:0]  kdim_m1;
    logic [NEU_AW-1:0] ndim_m1;
    logic              last_elem;
    logic              last_neu;
    logic              out_free;
    logic              push;
    logic [W_AW-1:0]   w_raddr;
    logic [VAL_W-1:0]  weight_q;
    logic [VAL_W-1:0]  bias_q;
    logic [VAL_W-1:0]  elem_q;

    fcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign in_acc     = i_in.valid && i_in.ready;
    assign func       = t_func'(i_in.func);
    assign n_elem_cnt = r_elem_cnt + DIM_W'(1);
    assign we_w       = in_acc && (func == FN_LOAD_W) && (32'(i_in.param_index) < W_DEPTH);
    assign we_b       = in_acc && (func == FN_LOAD_B) && (32'(i_in.param_index) < MAX_NEURONS);
    assign we_x       = in_acc && (func == FN_ELEM);
    assign start      = we_x && (n_elem_cnt >= w_cfg.kdim);

    assign kdim_m1   = IN_AW'(w_cfg.kdim - DIM_W'(1));
    assign ndim_m1   = NEU_AW'(w_cfg.ndim - DIM_W'(1));
    assign last_elem = (r_elem == kdim_m1);
    assign last_neu  = (r_neuron == ndim_m1);
    assign out_free  = !r_out_vld || o_res.ready;
    assign push      = (r_state == ST_PUSH) && out_free;
    assign w_raddr   = r_base + W_AW'(r_elem);

    fcl_ram #(.DEPTH(W_DEPTH), .WIDTH(VAL_W)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (we_w),
        .i_waddr (W_AW'(i_in.param_index)),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr),
        .o_rdata (weight_q)
    );

    fcl_ram #(.DEPTH(MAX_NEURONS), .WIDTH(VAL_W)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (NEU_AW'(i_in.param_index)),
        .i_wdata (i_in.value),
        .i_raddr (r_neuron),
        .o_rdata (bias_q)
    );

    fcl_ram #(.DEPTH(MAX_INPUTS), .WIDTH(VAL_W)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (we_x),
        .i_waddr (r_elem_cnt[IN_AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_elem),
        .o_rdata (elem_q)
    );

    fcl_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s1_ctl),
        .i_weight (weight_q),
        .i_elem   (elem_q),
        .i_bias   (bias_q),
        .o_sts    (w_mac_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_elem_cnt <= '0;
            r_s1_ctl   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            // control travels alongside the registered memory reads
            r_s1_ctl <= '{vld: (r_state == ST_RUN), first: (r_elem == '0), last: last_elem};

            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            if (w_cfg.clr) begin
                r_elem_cnt <= '0;
            end else if (we_x) begin
                r_elem_cnt <= start ? '0 : n_elem_cnt;
            end

            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state  <= ST_RUN;
                        r_elem   <= '0;
                        r_neuron <= '0;
                        r_base   <= '0;
                    end
                end
                ST_RUN: begin
                    r_elem <= r_elem + IN_AW'(1);
                    if (last_elem) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_mac_sts.done) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        r_out_neuron <= r_neuron;
                        r_out_val    <= w_mac_sts.result;
                        r_out_last   <= last_neu;
                        if (last_neu) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state  <= ST_RUN;
                            r_neuron <= r_neuron + NEU_AW'(1);
                            r_base   <= r_base + W_AW'(w_cfg.kdim);
                            r_elem   <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.neuron       = NEURON_W'(r_out_neuron);
    assign o_res.result_value = r_out_val;
    assign o_res.last         = r_out_last;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_sts.done |-> r_state == ST_WAIT)
        else $error("mac finished outside the wait step");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_elem <= kdim_m1)
        else $error("element sweep ran past the pattern length");

    a_last_neuron: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_last |-> r_out_neuron == ndim_m1)
        else $error("last flag on a neuron other than the final one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem_cnt < w_cfg.kdim)
        else $error("element count reached the pattern length");

endmodule

### rtl/core/fcl_ram.sv
// fcl_ram: generic simple dual-port memory, one write and one registered read
// depends on nothing
module fcl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fcl_cfg.sv
// fcl_cfg: apb register file for the pattern length and neuron count
// depends on fcl_pkg; hands clamped dimensions and a write strobe to the core
module fcl_cfg import fcl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [DIM_W-1:0] r_inputs;
    logic [DIM_W-1:0] r_neurons;
    logic             wr;
    t_reg_idx         sel;

    // zero acts as one, anything above the store size as the store size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (32'(v) > maxv) begin
            return DIM_W'(maxv);
        end
        return v;
    endfunction

    assign wr  = psel && penable && pwrite;
    assign sel = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs  <= DIM_W'(MAX_INPUTS);
            r_neurons <= DIM_W'(MAX_NEURONS);
        end else if (wr) begin
            case (sel)
                REG_INPUTS:  r_inputs  <= pwdata[DIM_W-1:0];
                REG_NEURONS: r_neurons <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_INPUTS:  prdata = APB_DATA_W'(r_inputs);
            REG_NEURONS: prdata = APB_DATA_W'(r_neurons);
            default:     prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_cfg.kdim = clamp_dim(r_inputs, MAX_INPUTS);
    assign o_cfg.ndim = clamp_dim(r_neurons, MAX_NEURONS);
    assign o_cfg.clr  = wr;

endmodule

### rtl/core/fcl_mac.sv
// fcl_mac: the shared multiply-accumulate unit, product stage then accumulator
// depends on fcl_pkg; saturates the result taken from the running sum to signed q8.24
module fcl_mac import fcl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [VAL_W-1:0] i_weight,
    input  logic signed [VAL_W-1:0] i_elem,
    input  logic signed [VAL_W-1:0] i_bias,
    output t_mac_sts                o_sts
);

    t_mac_ctl                  r_s2_ctl;
    logic signed [2*VAL_W-1:0] r_prod;
    logic signed [VAL_W-1:0]   r_s2_bias;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [ACC_W-1:0]   n_base;
    logic signed [ACC_W-1:0]   bias_ext;
    logic [ACC_W-RES_W:0]      top_bits;

    // bias q4.12 moved up to q8.24
    assign bias_ext = {{(ACC_W-VAL_W-FRAC_W){r_s2_bias[VAL_W-1]}}, r_s2_bias, {FRAC_W{1'b0}}};
    assign n_base   = r_s2_ctl.first ? bias_ext : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
            r_done   <= 1'b0;
        end else begin
            r_s2_ctl <= i_ctl;
            r_done   <= r_s2_ctl.vld && r_s2_ctl.last;
        end
        r_prod    <= i_weight * i_elem;
        r_s2_bias <= i_bias;
        if (r_s2_ctl.vld) begin
            r_acc <= n_base + ACC_W'(r_prod);
        end
    end

    // sum fits when every bit above the result's sign bit matches it
    assign top_bits = r_acc[ACC_W-1:RES_W-1];

    always_comb begin
        o_sts.done = r_done;
        if (top_bits == '0 || top_bits == '1) begin
            o_sts.result = r_acc[RES_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_sts.result = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            o_sts.result = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

endmodule
